// ===== hdl/otavg_pkg.sv =====
// Shared types, sizes and the position threshold table for the trimmed-mean averager.
// Used by every module of the olympic_trimmed_average_core block; depends on nothing.
package otavg_pkg;

   localparam int CHANNELS      = 6;
   localparam int AVG_SHIFT     = 3;
   localparam int TABLE_ENTRIES = 27;

   localparam int SAMPLE_W = 12;
   localparam int CHAN_W   = 3;
   localparam int CODE_W   = 8;
   localparam int NSAMP    = (1 << AVG_SHIFT) + 2;
   localparam int COUNT_W  = $clog2(NSAMP);
   localparam int SUM_W    = SAMPLE_W + COUNT_W;

   localparam int TABLE_SIZE = 27;
   localparam int SEARCH_LEN = (TABLE_ENTRIES > TABLE_SIZE) ? TABLE_SIZE : TABLE_ENTRIES;

   localparam logic [CODE_W-1:0] NONE_FOUND = 8'hff;

   localparam logic [0:0] REG_POSITION_CHANNEL = 1'b0;
   localparam logic [0:0] REG_UNPLUGGED_CODE   = 1'b1;

   localparam logic [SAMPLE_W-1:0] THR_TAB [TABLE_SIZE] = '{
      12'd108,  12'd294,  12'd452,  12'd635,  12'd804,  12'd943,  12'd1082,
      12'd1228, 12'd1389, 12'd1563, 12'd1751, 12'd1946, 12'd2140, 12'd2345,
      12'd2544, 12'd2723, 12'd2901, 12'd3065, 12'd3200, 12'd3317, 12'd3439,
      12'd3557, 12'd3667, 12'd3780, 12'd3906, 12'd4034, 12'd4095
   };

   // The last entry is replaced by the programmable unplugged code.
   localparam logic [CODE_W-1:0] CODE_TAB [TABLE_SIZE] = '{
      8'd91, 8'd26, 8'd16, 8'd21, 8'd11, 8'd22, 8'd12, 8'd23, 8'd13,
      8'd24, 8'd14, 8'd25, 8'd15, 8'd92, 8'd46, 8'd36, 8'd41, 8'd31,
      8'd42, 8'd32, 8'd43, 8'd33, 8'd44, 8'd34, 8'd45, 8'd35, 8'hff
   };

   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] min;
      logic [SAMPLE_W-1:0] max;
      logic [CHAN_W-1:0]   channel;
   } acc_token_type;

endpackage

// ===== hdl/otavg_accum.sv =====
// Sample accumulator: running sum, minimum, maximum and count for the current channel.
// Hands a finished channel to the decode stage as one token; uses otavg_pkg.
module otavg_accum (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [otavg_pkg::SAMPLE_W-1:0] req_sample,
   output logic                           req_stall,
   input  logic                           sink_free,
   output logic                           tok_valid,
   output otavg_pkg::acc_token_type       tok
);

   logic [otavg_pkg::SUM_W-1:0]    sum_ff, sum_in, sum_total;
   logic [otavg_pkg::SAMPLE_W-1:0] min_ff, min_in, min_new;
   logic [otavg_pkg::SAMPLE_W-1:0] max_ff, max_in, max_new;
   logic [otavg_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [otavg_pkg::CHAN_W-1:0]   chan_ff, chan_in;
   logic [otavg_pkg::CHAN_W:0]     chan_inc;
   logic                           tok_vld_ff, tok_vld_in;
   otavg_pkg::acc_token_type       tok_ff, tok_in;
   logic                           last_pending, accept;

   assign last_pending = (count_ff == otavg_pkg::COUNT_W'(otavg_pkg::NSAMP - 1));
   assign req_stall    = last_pending && tok_vld_ff && !sink_free;
   assign accept       = req_valid && !req_stall;

   assign sum_total = sum_ff + {{otavg_pkg::COUNT_W{1'b0}}, req_sample};
   assign min_new   = (req_sample < min_ff) ? req_sample : min_ff;
   assign max_new   = (req_sample > max_ff) ? req_sample : max_ff;
   assign chan_inc  = {1'b0, chan_ff} + 1'b1;

   always_comb begin
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      count_in   = count_ff;
      chan_in    = chan_ff;
      tok_in     = tok_ff;
      tok_vld_in = tok_vld_ff && !sink_free;
      if (accept) begin
         if (last_pending) begin
            sum_in         = '0;
            min_in         = '1;
            max_in         = '0;
            count_in       = '0;
            tok_in.sum     = sum_total;
            tok_in.min     = min_new;
            tok_in.max     = max_new;
            tok_in.channel = chan_ff;
            tok_vld_in     = 1'b1;
            if (chan_inc >= (otavg_pkg::CHAN_W + 1)'(otavg_pkg::CHANNELS)) begin
               chan_in = '0;
            end else begin
               chan_in = chan_inc[otavg_pkg::CHAN_W-1:0];
            end
         end else begin
            sum_in   = sum_total;
            min_in   = min_new;
            max_in   = max_new;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         min_ff     <= '1;
         max_ff     <= '0;
         count_ff   <= '0;
         chan_ff    <= '0;
         tok_vld_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         count_ff   <= count_in;
         chan_ff    <= chan_in;
         tok_vld_ff <= tok_vld_in;
      end
      tok_ff <= tok_in;
   end

   assign tok_valid = tok_vld_ff;
   assign tok       = tok_ff;

endmodule

// ===== hdl/otavg_decode.sv =====
// Trimmed-mean and position decode stage with the result register and the two settings.
// Takes finished tokens from otavg_accum; uses otavg_pkg for sizes and the threshold table.
module otavg_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [0:0]                     csr_index,
   input  logic [otavg_pkg::CODE_W-1:0]   csr_wdata,
   input  logic                           tok_valid,
   input  otavg_pkg::acc_token_type       tok,
   output logic                           sink_free,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [otavg_pkg::CHAN_W-1:0]   rsp_channel,
   output logic [otavg_pkg::SAMPLE_W-1:0] rsp_average,
   output logic [otavg_pkg::CODE_W-1:0]   rsp_position_code,
   output logic                           rsp_is_position
);

   logic [otavg_pkg::CHAN_W-1:0]   pos_chan_ff;
   logic [otavg_pkg::CODE_W-1:0]   unplugged_ff;
   logic                           valid_ff, valid_in;
   logic [otavg_pkg::CHAN_W-1:0]   chan_ff;
   logic [otavg_pkg::SAMPLE_W-1:0] avg_ff;
   logic [otavg_pkg::CODE_W-1:0]   code_ff;
   logic                           is_pos_ff;
   logic [otavg_pkg::SUM_W-1:0]    trimmed;
   logic [otavg_pkg::SAMPLE_W-1:0] avg;
   logic [otavg_pkg::CODE_W-1:0]   found_code;
   logic                           is_pos;

   assign sink_free = !valid_ff || !rsp_stall;
   assign valid_in  = sink_free ? tok_valid : valid_ff;

   assign trimmed = tok.sum - {{otavg_pkg::COUNT_W{1'b0}}, tok.min}
                            - {{otavg_pkg::COUNT_W{1'b0}}, tok.max};
   assign avg     = trimmed[otavg_pkg::AVG_SHIFT +: otavg_pkg::SAMPLE_W];
   assign is_pos  = (tok.channel == pos_chan_ff);

   // Priority search: the lowest entry whose threshold exceeds the average wins.
   always_comb begin
      found_code = otavg_pkg::NONE_FOUND;
      for (int k = otavg_pkg::SEARCH_LEN - 1; k >= 0; k--) begin
         if (otavg_pkg::THR_TAB[k] > avg) begin
            if (k == otavg_pkg::TABLE_SIZE - 1) begin
               found_code = unplugged_ff;
            end else begin
               found_code = otavg_pkg::CODE_TAB[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_chan_ff  <= otavg_pkg::CHAN_W'(4);
         unplugged_ff <= 8'hff;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               otavg_pkg::REG_POSITION_CHANNEL: begin
                  pos_chan_ff <= csr_wdata[otavg_pkg::CHAN_W-1:0];
               end
               otavg_pkg::REG_UNPLUGGED_CODE: begin
                  unplugged_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
      if (sink_free && tok_valid) begin
         chan_ff   <= tok.channel;
         avg_ff    <= avg;
         code_ff   <= is_pos ? found_code : '0;
         is_pos_ff <= is_pos;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_channel       = chan_ff;
   assign rsp_average       = avg_ff;
   assign rsp_position_code = code_ff;
   assign rsp_is_position   = is_pos_ff;

endmodule

// ===== hdl/olympic_trimmed_average_core.sv =====
// Top level of the olympic trimmed-mean averager for round-robin ADC channels.
// Instantiates otavg_accum and otavg_decode; uses otavg_pkg.
//
// Each request carries one 12-bit sample for the current channel. After ten samples
// (2^3 + 2) the block reports the channel and the sum less its smallest and largest
// sample, divided by eight, then moves on to the next of six channels in turn. For the
// channel set in register 0 the report also carries a position code: the code of the
// first threshold above the average, register 1 for the last entry, or 255 if none.
// One request is taken every clock cycle unless req_stall holds it off; after the tenth
// request is taken, its report passes through the accumulator's hand-off register, then
// through the subtract and table compare into the result register. While a report is
// held by rsp_stall, requests keep being accepted until the next channel's tenth sample
// finds the hand-off register still full.
module olympic_trimmed_average_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [otavg_pkg::SAMPLE_W-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [otavg_pkg::CHAN_W-1:0]   rsp_channel,
   output logic [otavg_pkg::SAMPLE_W-1:0] rsp_average,
   output logic [otavg_pkg::CODE_W-1:0]   rsp_position_code,
   output logic                           rsp_is_position,
   input  logic                           csr_wr_en,
   input  logic [0:0]                     csr_index,
   input  logic [otavg_pkg::CODE_W-1:0]   csr_wdata
);

   logic                     sink_free;
   logic                     tok_valid;
   otavg_pkg::acc_token_type tok;

   otavg_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_sample (req_sample),
      .req_stall  (req_stall),
      .sink_free  (sink_free),
      .tok_valid  (tok_valid),
      .tok        (tok)
   );

   otavg_decode u_decode (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .tok_valid         (tok_valid),
      .tok               (tok),
      .sink_free         (sink_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel       (rsp_channel),
      .rsp_average       (rsp_average),
      .rsp_position_code (rsp_position_code),
      .rsp_is_position   (rsp_is_position)
   );

endmodule

// ===== hdl/otavg_checker.sv =====
// Port-level assertions for olympic_trimmed_average_core, attached by the bind below.
// Sees only the top-level ports; uses otavg_pkg for widths.
module otavg_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [otavg_pkg::CHAN_W-1:0]   rsp_channel,
   input logic [otavg_pkg::SAMPLE_W-1:0] rsp_average,
   input logic [otavg_pkg::CODE_W-1:0]   rsp_position_code,
   input logic                           rsp_is_position
);

   // A held result keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel) && $stable(rsp_average)
         && $stable(rsp_position_code) && $stable(rsp_is_position))
      else $error("stalled result changed");

   // Requests are only held off while a finished result is itself held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output back-pressure");

   // A channel that is not the position channel reports a zero code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_position |-> rsp_position_code == '0)
      else $error("position code set on a plain channel");

   // Reported channels stay within the configured channel count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel < otavg_pkg::CHAN_W'(otavg_pkg::CHANNELS)
         || otavg_pkg::CHANNELS == 8)
      else $error("channel out of range");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

endmodule

bind olympic_trimmed_average_core otavg_checker u_otavg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_channel       (rsp_channel),
   .rsp_average       (rsp_average),
   .rsp_position_code (rsp_position_code),
   .rsp_is_position   (rsp_is_position)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for olympic_trimmed_average_core.
// It drives ADC sample requests and checks each trimmed-mean report against a local predictor.
// Depends on otavg_pkg and the olympic_trimmed_average_core RTL only.
`timescale 1ns / 100ps

module testbench;
   import otavg_pkg::*;

   localparam int TRIM_SHIFT   = 3;
   localparam int NUM_CHANNELS = 6;
   localparam int BATCH        = (1 << TRIM_SHIFT) + 2;
   localparam int SEARCH_LEN_TB = 27;
   localparam int LAST_ENTRY   = 26;
   localparam logic [7:0] NO_MATCH = 8'hff;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 80;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 160;
   localparam int DIR_ROWS      = 12;

   localparam int unsigned THRESHOLDS [27] = '{
      108, 294, 452, 635, 804, 943, 1082, 1228, 1389, 1563, 1751, 1946, 2140,
      2345, 2544, 2723, 2901, 3065, 3200, 3317, 3439, 3557, 3667, 3780, 3906,
      4034, 4095
   };

   localparam logic [7:0] POS_CODES [26] = '{
      8'd91, 8'd26, 8'd16, 8'd21, 8'd11, 8'd22, 8'd12, 8'd23, 8'd13, 8'd24, 8'd14,
      8'd25, 8'd15, 8'd92, 8'd46, 8'd36, 8'd41, 8'd31, 8'd42, 8'd32, 8'd43, 8'd33,
      8'd44, 8'd34, 8'd45, 8'd35
   };

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] average;
      logic [CODE_W-1:0]   code;
      logic                is_position;
   } report_type;

   typedef struct {
      int mid;
      int lo;
      int hi;
      int lo_at;
      int hi_at;
      bit typed;
      int e_chan;
      int e_avg;
      int e_code;
      int e_pos;
   } drow_type;

   // Each row is one full channel batch: eight middle samples and two outliers.
   drow_type dir_rows [DIR_ROWS] = '{
      '{0,    0,    0,    0, 9, 1'b1, 0, 0,    0,   0},
      '{4095, 4095, 4095, 0, 9, 1'b1, 1, 4095, 0,   0},
      '{1000, 0,    4095, 0, 9, 1'b0, 0, 0,    0,   0},
      '{2048, 5,    4000, 9, 0, 1'b0, 0, 0,    0,   0},
      '{4095, 4095, 4095, 3, 4, 1'b1, 4, 4095, 255, 1},
      '{107,  0,    4095, 5, 2, 1'b0, 0, 0,    0,   0},
      '{2345, 2344, 2346, 1, 8, 1'b0, 0, 0,    0,   0},
      '{3000, 0,    4095, 7, 6, 1'b0, 0, 0,    0,   0},
      '{4094, 4093, 4095, 2, 3, 1'b0, 0, 0,    0,   0},
      '{1,    0,    2,    8, 1, 1'b0, 0, 0,    0,   0},
      '{4034, 0,    4095, 4, 5, 1'b0, 0, 0,    0,   0},
      '{2047, 1024, 3072, 6, 7, 1'b0, 0, 0,    0,   0}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [CHAN_W-1:0]   rsp_channel;
   logic [SAMPLE_W-1:0] rsp_average;
   logic [CODE_W-1:0]   rsp_position_code;
   logic                rsp_is_position;
   logic                csr_wr_en;
   logic [0:0]          csr_index;
   logic [CODE_W-1:0]   csr_wdata;

   int unsigned acc_sum;
   int unsigned acc_min;
   int unsigned acc_max;
   int          acc_count;
   int          cur_chan;
   logic [2:0]  cfg_pos_chan;
   logic [7:0]  cfg_unplugged;
   int          batch_level;

   report_type pending_reports [$];
   int      mismatches;
   int      reports_seen;
   int      samples_sent;
   int      send_idle_pct;
   int      recv_idle_pct;
   bit      hold_toggle;
   bit      hold_seen;
   int      hold_left;

   olympic_trimmed_average_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel       (rsp_channel),
      .rsp_average       (rsp_average),
      .rsp_position_code (rsp_position_code),
      .rsp_is_position   (rsp_is_position),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] position_code_of(input int unsigned avg);
      for (int k = 0; k < SEARCH_LEN_TB; k++) begin
         if (THRESHOLDS[k] > avg) begin
            return (k == LAST_ENTRY) ? cfg_unplugged : POS_CODES[k];
         end
      end
      return NO_MATCH;
   endfunction

   function automatic void clear_batch();
      acc_sum   = 0;
      acc_min   = 4095;
      acc_max   = 0;
      acc_count = 0;
   endfunction

   function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] value,
                                            output report_type rep);
      int unsigned avg;
      rep = '0;
      acc_sum += value;
      if (value < acc_min) acc_min = value;
      if (value > acc_max) acc_max = value;
      acc_count++;
      if (acc_count < BATCH) return 1'b0;
      avg = ((acc_sum - acc_min - acc_max) >> TRIM_SHIFT) & 32'hfff;
      rep.channel = cur_chan[2:0];
      rep.average = avg[SAMPLE_W-1:0];
      if (cur_chan == cfg_pos_chan) begin
         rep.code        = position_code_of(avg);
         rep.is_position = 1'b1;
      end
      clear_batch();
      cur_chan = (cur_chan + 1 >= NUM_CHANNELS) ? 0 : cur_chan + 1;
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      int v;
      int pick;
      if (acc_count == 0) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            batch_level = int'(THRESHOLDS[$urandom_range(26)]) + int'($urandom_range(6)) - 3;
         end else if (pick < 65) begin
            batch_level = $urandom_range(1) ? 4095 : 0;
         end else begin
            batch_level = $urandom_range(4095);
         end
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
         v = batch_level + int'($urandom_range(4)) - 2;
      end else if (pick < 85) begin
         v = $urandom_range(4095);
      end else begin
         v = $urandom_range(1) ? 4095 : 0;
      end
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit typed,
                              input report_type typed_rep);
      report_type rep;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
      if (accumulate_sample(value, rep)) pending_reports.push_back(typed ? typed_rep : rep);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [2:0] pos_chan, input logic [7:0] unplugged);
      csr_wr_en <= 1'b1;
      csr_index <= REG_POSITION_CHANNEL;
      csr_wdata <= {5'd0, pos_chan};
      @(posedge clock);
      cfg_pos_chan = pos_chan;
      csr_index <= REG_UNPLUGGED_CODE;
      csr_wdata <= unplugged;
      @(posedge clock);
      cfg_unplugged = unplugged;
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : result_checker
      report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected report, expected none, got channel %0d average %0d",
                        $time, rsp_channel, rsp_average);
            end else begin
               want = pending_reports.pop_front();
               if (rsp_channel !== want.channel) begin
                  mismatches++;
                  $display("%0t: channel mismatch, expected %0d, got %0d",
                           $time, want.channel, rsp_channel);
               end
               if (rsp_average !== want.average) begin
                  mismatches++;
                  $display("%0t: average mismatch, expected %0d, got %0d",
                           $time, want.average, rsp_average);
               end
               if (rsp_position_code !== want.code) begin
                  mismatches++;
                  $display("%0t: position_code mismatch, expected %0d, got %0d",
                           $time, want.code, rsp_position_code);
               end
               if (rsp_is_position !== want.is_position) begin
                  mismatches++;
                  $display("%0t: is_position mismatch, expected %0d, got %0d",
                           $time, want.is_position, rsp_is_position);
               end
            end
         end
         if (hold_seen != hold_toggle) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      #3ms;
      $display("[olympic_trimmed_average_core] ERROR");
      $finish;
   end

   initial begin : stimulus
      report_type typed_rep;
      int      value;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      rsp_stall    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = REG_POSITION_CHANNEL;
      csr_wdata    = '0;
      mismatches   = 0;
      reports_seen = 0;
      samples_sent = 0;
      hold_toggle  = 1'b0;
      hold_seen    = 1'b0;
      hold_left    = 0;
      batch_level  = 0;
      cfg_pos_chan  = 3'd4;
      cfg_unplugged = 8'hff;
      cur_chan      = 0;
      clear_batch();
      send_idle_pct = 23;
      recv_idle_pct = 66;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         typed_rep.channel     = dir_rows[r].e_chan[CHAN_W-1:0];
         typed_rep.average     = dir_rows[r].e_avg[SAMPLE_W-1:0];
         typed_rep.code        = dir_rows[r].e_code[CODE_W-1:0];
         typed_rep.is_position = dir_rows[r].e_pos[0];
         for (int i = 0; i < BATCH; i++) begin
            value = (i == dir_rows[r].lo_at) ? dir_rows[r].lo :
                    (i == dir_rows[r].hi_at) ? dir_rows[r].hi : dir_rows[r].mid;
            send_sample(value[SAMPLE_W-1:0], dir_rows[r].typed && (i == BATCH - 1), typed_rep);
         end
      end
      wait_for_drain();

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = (p < 2) ? 23 : (p < 4) ? 66 : 0;
         recv_idle_pct = (p < 2) ? 66 : (p < 4) ? 23 : 0;
         case (p)
            0: program_regs(3'd0, 8'd0);
            1: program_regs(3'd7, 8'd200);
            2: program_regs(3'd5, 8'd255);
            3: program_regs(3'd4, 8'($urandom_range(255)));
            4: program_regs(3'd2, 8'd1);
            default: program_regs(3'd6, 8'd128);
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 60 && (p == 0 || p == 4)) hold_toggle <= ~hold_toggle;
            send_sample(random_sample(), 1'b0, '0);
         end
         wait_for_drain();
      end
      repeat (20) @(posedge clock);

      $display("Sent %0d samples and checked %0d channel reports over %0d register settings,",
               samples_sent, reports_seen, PHASES + 1);
      $display("with idle and stall on both sides, a long result hold and full-rate streams.");
      if (mismatches == 0) begin
         $display("[olympic_trimmed_average_core] OK");
      end else begin
         $display("[olympic_trimmed_average_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/otavg_pkg.sv
hdl/otavg_accum.sv
hdl/otavg_decode.sv
hdl/olympic_trimmed_average_core.sv
hdl/otavg_checker.sv
tb/sv/testbench.sv
